### design/jhacs_pkg.sv
// ----------------------------------------------------------------------------
// jhacs_pkg
// Shared types and constants for the joystick height and arm command shaper.
// ----------------------------------------------------------------------------
package jhacs_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HEIGHT_MIN        = 3'd0;
    localparam logic [2:0] REG_HEIGHT_MAX        = 3'd1;
    localparam logic [2:0] REG_LIFT_INCREMENT    = 3'd2;
    localparam logic [2:0] REG_AXIS_DEAD_BAND    = 3'd3;
    localparam logic [2:0] REG_VELOCITY_LIMIT    = 3'd4;
    localparam logic [2:0] REG_LOW_STANCE_HEIGHT = 3'd5;
    localparam logic [2:0] REG_TARGET_MIX        = 3'd6;
    localparam logic [2:0] REG_ARM_RETURN_SPEED  = 3'd7;

    // Register values after reset.
    localparam logic [12:0] RST_HEIGHT_MIN        = 13'd1229;
    localparam logic [12:0] RST_HEIGHT_MAX        = 13'd3113;
    localparam logic [10:0] RST_LIFT_INCREMENT    = 11'd82;
    localparam logic [12:0] RST_AXIS_DEAD_BAND    = 13'd410;
    localparam logic [14:0] RST_VELOCITY_LIMIT    = 15'd4096;
    localparam logic [12:0] RST_LOW_STANCE_HEIGHT = 13'd3031;
    localparam logic [12:0] RST_TARGET_MIX        = 13'd819;
    localparam logic [14:0] RST_ARM_RETURN_SPEED  = 15'd1434;

    // Item kinds carried in tuser.
    localparam logic OP_JOYSTICK = 1'b0;
    localparam logic OP_JOINT    = 1'b1;

    // Elapsed time cap (0.05 s in 2^-16 s) and unity blend weight in Q1.12.
    localparam logic [15:0] ELAPSED_CAP = 16'd3277;
    localparam logic [12:0] BLEND_ONE   = 13'd4096;

    localparam int CFG_DATA_W = 15;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;

    // Configuration register set.
    typedef struct packed {
        logic [12:0] height_min;
        logic [12:0] height_max;
        logic [10:0] lift_increment;
        logic [12:0] axis_dead_band;
        logic [14:0] velocity_limit;
        logic [12:0] low_stance_height;
        logic [12:0] target_mix;
        logic [14:0] arm_return_speed;
    } t_cfg;

    // One input item, unpacked from the stream.
    typedef struct packed {
        logic               operation;
        logic               up_button;
        logic               down_button;
        logic signed [13:0] stick_forward;
        logic signed [13:0] stick_side;
        logic signed [13:0] stick_turn;
        logic [2:0]         joint_index;
        logic signed [15:0] policy_action;
        logic               ik_valid;
        logic signed [15:0] ik_target;
        logic [15:0]        elapsed_time;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [15:0] forward_velocity;
        logic signed [15:0] side_velocity;
        logic signed [15:0] turn_rate;
        logic [12:0]        height_target;
        logic signed [15:0] joint_command;
    } t_out_item;

endpackage

### design/jhacs_regs.sv
// ----------------------------------------------------------------------------
// jhacs_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module jhacs_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [2:0]                          i_cfg_addr,
    input  logic [jhacs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output jhacs_pkg::t_cfg                     o_cfg
);

    jhacs_pkg::t_cfg r_cfg;

    // Each register keeps the low bits of the written data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_min        <= jhacs_pkg::RST_HEIGHT_MIN;
            r_cfg.height_max        <= jhacs_pkg::RST_HEIGHT_MAX;
            r_cfg.lift_increment    <= jhacs_pkg::RST_LIFT_INCREMENT;
            r_cfg.axis_dead_band    <= jhacs_pkg::RST_AXIS_DEAD_BAND;
            r_cfg.velocity_limit    <= jhacs_pkg::RST_VELOCITY_LIMIT;
            r_cfg.low_stance_height <= jhacs_pkg::RST_LOW_STANCE_HEIGHT;
            r_cfg.target_mix        <= jhacs_pkg::RST_TARGET_MIX;
            r_cfg.arm_return_speed  <= jhacs_pkg::RST_ARM_RETURN_SPEED;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                jhacs_pkg::REG_HEIGHT_MIN:
                    r_cfg.height_min        <= i_cfg_wdata[12:0];
                jhacs_pkg::REG_HEIGHT_MAX:
                    r_cfg.height_max        <= i_cfg_wdata[12:0];
                jhacs_pkg::REG_LIFT_INCREMENT:
                    r_cfg.lift_increment    <= i_cfg_wdata[10:0];
                jhacs_pkg::REG_AXIS_DEAD_BAND:
                    r_cfg.axis_dead_band    <= i_cfg_wdata[12:0];
                jhacs_pkg::REG_VELOCITY_LIMIT:
                    r_cfg.velocity_limit    <= i_cfg_wdata[14:0];
                jhacs_pkg::REG_LOW_STANCE_HEIGHT:
                    r_cfg.low_stance_height <= i_cfg_wdata[12:0];
                jhacs_pkg::REG_TARGET_MIX:
                    r_cfg.target_mix        <= i_cfg_wdata[12:0];
                jhacs_pkg::REG_ARM_RETURN_SPEED:
                    r_cfg.arm_return_speed  <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/jhacs_joy.sv
// ----------------------------------------------------------------------------
// jhacs_joy
// Height target state with button edge detection, and stick axis shaping.
// ----------------------------------------------------------------------------
module jhacs_joy (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jhacs_pkg::t_cfg            i_cfg,
    input  jhacs_pkg::t_in_item        i_item,
    input  logic                       i_fire,
    output logic [12:0]                o_height,
    output logic signed [15:0]         o_forward,
    output logic signed [15:0]         o_side,
    output logic signed [15:0]         o_turn
);

    logic [12:0]        r_level;
    logic               r_loaded;
    logic               r_up_prev;
    logic               r_down_prev;

    logic [12:0]        w_height_cur;
    logic signed [14:0] w_h_sum;
    logic signed [14:0] w_h_max;
    logic signed [14:0] w_h_min;
    logic signed [14:0] w_h_clamp;
    logic [12:0]        n_level;
    logic               w_joy;
    logic signed [14:0] w_fwd_in;
    logic signed [14:0] w_side_in;
    logic signed [14:0] w_turn_in;
    logic signed [15:0] w_fwd;
    logic signed [15:0] w_side;
    logic signed [15:0] w_turn;

    // Deadzone on magnitude, then symmetric clamp.
    function automatic logic signed [15:0] shape(input logic signed [14:0] v,
                                                 input logic [12:0] dz,
                                                 input logic [14:0] lim);
        logic signed [15:0] vx;
        logic signed [15:0] mag;
        logic signed [15:0] limx;
        logic signed [15:0] res;
        vx   = {v[14], v};
        mag  = (vx < 16'sd0) ? -vx : vx;
        limx = $signed({1'b0, lim});
        res  = (mag < $signed({3'b000, dz})) ? 16'sd0 : vx;
        if (res > limx) begin
            res = limx;
        end
        if (res < -limx) begin
            res = -limx;
        end
        return res;
    endfunction

    assign w_joy        = (i_item.operation == jhacs_pkg::OP_JOYSTICK);
    assign w_height_cur = r_loaded ? r_level : i_cfg.height_max;

    // Step on rising button edges, then limit to max and raise to min.
    always_comb begin
        w_h_sum = $signed({2'b00, w_height_cur});
        if (i_item.up_button && !r_up_prev) begin
            w_h_sum = w_h_sum + $signed({4'b0000, i_cfg.lift_increment});
        end
        if (i_item.down_button && !r_down_prev) begin
            w_h_sum = w_h_sum - $signed({4'b0000, i_cfg.lift_increment});
        end
        w_h_max   = $signed({2'b00, i_cfg.height_max});
        w_h_min   = $signed({2'b00, i_cfg.height_min});
        w_h_clamp = w_h_sum;
        if (w_h_clamp > w_h_max) begin
            w_h_clamp = w_h_max;
        end
        if (w_h_clamp < w_h_min) begin
            w_h_clamp = w_h_min;
        end
        n_level = w_h_clamp[12:0];
    end

    // Side and turn axes are negated before shaping.
    assign w_fwd_in  = {i_item.stick_forward[13], i_item.stick_forward};
    assign w_side_in = -$signed({i_item.stick_side[13], i_item.stick_side});
    assign w_turn_in = -$signed({i_item.stick_turn[13], i_item.stick_turn});

    assign w_fwd  = shape(w_fwd_in,  i_cfg.axis_dead_band, i_cfg.velocity_limit);
    assign w_side = shape(w_side_in, i_cfg.axis_dead_band, i_cfg.velocity_limit);
    assign w_turn = shape(w_turn_in, i_cfg.axis_dead_band, i_cfg.velocity_limit);

    assign o_height  = w_joy ? n_level : w_height_cur;
    assign o_forward = w_joy ? w_fwd  : 16'sd0;
    assign o_side    = w_joy ? w_side : 16'sd0;
    assign o_turn    = w_joy ? w_turn : 16'sd0;

    // Control state of the height tracker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_up_prev   <= 1'b0;
            r_down_prev <= 1'b0;
        end else if (i_fire && w_joy) begin
            r_loaded    <= 1'b1;
            r_up_prev   <= i_item.up_button;
            r_down_prev <= i_item.down_button;
        end
    end

    // Height level; only read once loaded.
    always_ff @(posedge i_clk) begin
        if (i_fire && w_joy) begin
            r_level <= n_level;
        end
    end

endmodule

### design/jhacs_arm.sv
// ----------------------------------------------------------------------------
// jhacs_arm
// Arm joint store with IK blend, slew toward zero and policy follow.
// ----------------------------------------------------------------------------
module jhacs_arm #(
    parameter int ARM_JOINTS = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jhacs_pkg::t_cfg            i_cfg,
    input  jhacs_pkg::t_in_item        i_item,
    input  logic                       i_fire,
    input  logic [12:0]                i_height,
    output logic signed [15:0]         o_joint
);

    localparam int IDX_W = (ARM_JOINTS > 1) ? $clog2(ARM_JOINTS) : 1;

    logic signed [15:0] r_store [ARM_JOINTS];

    logic [4:0]         w_idx_ext;
    logic [IDX_W-1:0]   w_sel;
    logic               w_in_range;
    logic               w_joint_op;
    logic               w_squat;
    logic signed [15:0] w_cur;
    logic [12:0]        w_blend;
    logic signed [16:0] w_diff;
    logic signed [30:0] w_bprod;
    logic signed [32:0] w_bsum;
    logic signed [20:0] w_bq;
    logic signed [15:0] w_blended;
    logic [11:0]        w_dt;
    logic [26:0]        w_sprod;
    logic [27:0]        w_sround;
    logic [10:0]        w_md;
    logic signed [16:0] w_mag;
    logic signed [15:0] w_slewed;
    logic signed [15:0] w_update;
    logic signed [15:0] n_store;

    assign w_idx_ext  = {2'b00, i_item.joint_index};
    assign w_sel      = w_idx_ext[IDX_W-1:0];
    assign w_in_range = (w_idx_ext < 5'(ARM_JOINTS));
    assign w_joint_op = (i_item.operation == jhacs_pkg::OP_JOINT);
    assign w_squat    = (i_height < i_cfg.low_stance_height);
    assign w_cur      = w_in_range ? r_store[w_sel] : 16'sd0;

    // Blend: cur + b*(target-cur), rounded half up in Q21.12, saturated.
    always_comb begin
        w_blend   = (i_cfg.target_mix > jhacs_pkg::BLEND_ONE) ? jhacs_pkg::BLEND_ONE
                                                              : i_cfg.target_mix;
        w_diff    = $signed({i_item.ik_target[15], i_item.ik_target})
                  - $signed({w_cur[15], w_cur});
        w_bprod   = w_diff * $signed({1'b0, w_blend});
        w_bsum    = ($signed({{5{w_cur[15]}}, w_cur, 12'd0}))
                  + $signed({{2{w_bprod[30]}}, w_bprod}) + 33'sd2048;
        w_bq      = w_bsum[32:12];
        if (w_bq > 21'sd32767) begin
            w_blended = 16'sd32767;
        end else if (w_bq < -21'sd32768) begin
            w_blended = -16'sd32768;
        end else begin
            w_blended = w_bq[15:0];
        end
    end

    // Slew toward zero by speed times capped elapsed time.
    always_comb begin
        w_dt     = (i_item.elapsed_time > jhacs_pkg::ELAPSED_CAP)
                 ? jhacs_pkg::ELAPSED_CAP[11:0] : i_item.elapsed_time[11:0];
        w_sprod  = i_cfg.arm_return_speed * w_dt;
        w_sround = {1'b0, w_sprod} + 28'd32768;
        w_md     = w_sround[26:16];
        w_mag    = (w_cur < 16'sd0) ? -$signed({w_cur[15], w_cur})
                                    : $signed({w_cur[15], w_cur});
        if (w_mag <= $signed({6'd0, w_md})) begin
            w_slewed = 16'sd0;
        end else if (w_cur > 16'sd0) begin
            w_slewed = w_cur - $signed({5'd0, w_md});
        end else begin
            w_slewed = w_cur + $signed({5'd0, w_md});
        end
    end

    assign w_update = i_item.ik_valid ? w_blended : w_slewed;
    assign n_store  = w_squat ? w_update : i_item.policy_action;

    // Command shown for the item; joystick items read zero.
    always_comb begin
        if (!w_joint_op) begin
            o_joint = 16'sd0;
        end else if (!w_in_range) begin
            o_joint = i_item.policy_action;
        end else begin
            o_joint = n_store;
        end
    end

    // Joint store, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ARM_JOINTS; i++) begin
                r_store[i] <= 16'sd0;
            end
        end else if (i_fire && w_joint_op && w_in_range) begin
            r_store[w_sel] <= n_store;
        end
    end

endmodule

### design/joystick_height_and_arm_command_shaper.sv
// ----------------------------------------------------------------------------
// joystick_height_and_arm_command_shaper
// Top level: input register, single-pass shaping logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel; tuser selects a joystick sample (0) or
//   an arm joint update (1). Every accepted item yields exactly one result on
//   the m_axis channel, in order. Configuration registers are written through
//   i_cfg_wr_en / i_cfg_addr / i_cfg_wdata while no item is in flight.
//   A transfer lands in the input register; the combinational shaping logic
//   then reads the height and joint state, updates it, and loads the result
//   register once that register is free or being emptied. Throughput is one
//   item per cycle while the receiver does not stall, set by the single pass
//   from the input register to the result register.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more item; s_axis_tready then drops until the result is taken.
//   Reset (synchronous, active low) empties both registers, restores register
//   defaults, clears all joint commands and the button history, and makes the
//   height target start from height_max.
// ----------------------------------------------------------------------------
module joystick_height_and_arm_command_shaper #(
    parameter int ARM_JOINTS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_wr_en,
    input  logic [2:0]                           i_cfg_addr,
    input  logic [jhacs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // up_button, down_button, stick_forward, stick_side, stick_turn,
    // joint_index, policy_action, ik_valid, ik_target, elapsed_time
    input  logic [jhacs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic [0:0]                           s_axis_tuser,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // forward_velocity, side_velocity, turn_rate, height_target,
    // joint_command, zero padding
    output logic [jhacs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    jhacs_pkg::t_cfg      w_cfg;
    jhacs_pkg::t_in_item  r_in;
    jhacs_pkg::t_in_item  n_in;
    jhacs_pkg::t_out_item r_out;
    jhacs_pkg::t_out_item n_out;
    logic                 r_in_vld;
    logic                 r_out_vld;
    logic                 w_adv;
    logic                 w_take;
    logic [12:0]          w_height;
    logic signed [15:0]   w_fwd;
    logic signed [15:0]   w_side;
    logic signed [15:0]   w_turn;
    logic signed [15:0]   w_joint;

    // Unpack the incoming transfer.
    always_comb begin
        n_in.operation     = s_axis_tuser[0];
        n_in.up_button     = s_axis_tdata[0];
        n_in.down_button   = s_axis_tdata[1];
        n_in.stick_forward = s_axis_tdata[15:2];
        n_in.stick_side    = s_axis_tdata[29:16];
        n_in.stick_turn    = s_axis_tdata[43:30];
        n_in.joint_index   = s_axis_tdata[46:44];
        n_in.policy_action = s_axis_tdata[62:47];
        n_in.ik_valid      = s_axis_tdata[63];
        n_in.ik_target     = s_axis_tdata[79:64];
        n_in.elapsed_time  = s_axis_tdata[95:80];
    end

    // Item moves on when the result register is free or being emptied.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    jhacs_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    jhacs_joy u_joy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_item    (r_in),
        .i_fire    (w_adv),
        .o_height  (w_height),
        .o_forward (w_fwd),
        .o_side    (w_side),
        .o_turn    (w_turn)
    );

    jhacs_arm #(
        .ARM_JOINTS (ARM_JOINTS)
    ) u_arm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_fire   (w_adv),
        .i_height (w_height),
        .o_joint  (w_joint)
    );

    // Gather the result.
    always_comb begin
        n_out.forward_velocity = w_fwd;
        n_out.side_velocity    = w_side;
        n_out.turn_rate        = w_turn;
        n_out.height_target    = w_height;
        n_out.joint_command    = w_joint;
    end

    // Valid flags of both registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= n_in;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out.joint_command, r_out.height_target,
                            r_out.turn_rate, r_out.side_velocity,
                            r_out.forward_velocity};

endmodule
